@@ hdl/oaie_pkg.sv @@
// Shared codes and field widths for the ordered array insert engine.
`timescale 1ns / 1ps

package oaie_pkg;

  // Field widths of the request and result transfers
  localparam int WORD_W    = 32;
  localparam int POS_W     = 8;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 7;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_POS_INS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH_INS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ      = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

endpackage

@@ hdl/oaie_store.sv @@
// Word store: one write port and one registered read port.
`timescale 1ns / 1ps

module oaie_store #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  oaie_pkg::word_t     wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output oaie_pkg::word_t     rdata
);
  import oaie_pkg::*;

  word_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/ordered_array_insert_engine.sv @@
// Top level: ordered word array with positional insert, insert-after-match and read.
// One request in work at a time; a stalled result holds done.
// A result waits in the output register, and the next request is taken meanwhile.
// Synchronous active-high reset empties the array (count zero); stored words are not cleared.
`timescale 1ns / 1ps

module ordered_array_insert_engine #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // value[31:0], position[39:32], target[71:40]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  // result
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // read_word[31:0], element_count[38:32],
                                 // inserted_count[45:39], zero pad[47:46]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import oaie_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_F_RD   = 4'd1;
  localparam logic [3:0] S_F_CMP  = 4'd2;
  localparam logic [3:0] S_B_INIT = 4'd3;
  localparam logic [3:0] S_B_RD   = 4'd4;
  localparam logic [3:0] S_B_WR   = 4'd5;
  localparam logic [3:0] S_B_MV   = 4'd6;
  localparam logic [3:0] S_PUT    = 4'd7;
  localparam logic [3:0] S_R_RD   = 4'd8;
  localparam logic [3:0] S_R_CAP  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]          state;
  logic [CW-1:0]       count;
  logic [KIND_W-1:0]   kind_r;
  word_t               value_r;
  word_t               target_r;
  logic [AW-1:0]       at;
  logic [AW-1:0]       j;
  logic [CW-1:0]       s;
  logic [CW-1:0]       m;
  logic [CW-1:0]       mrem;
  logic [CW-1:0]       k;
  logic [CW-1:0]       ins_cnt;
  logic [STATUS_W-1:0] st;
  word_t               rword;

  // Store port
  logic                we;
  logic [AW-1:0]       waddr;
  word_t               wdata;
  logic                re;
  logic [AW-1:0]       raddr;
  word_t               rdata;

  // Request decode
  logic [KIND_W-1:0]   in_kind;
  logic [XW-1:0]       pos_x;
  logic [XW-1:0]       cnt_x;
  logic                ins_bad;
  logic                rd_bad;

  // Shared compare and address unit
  logic                match_now;
  logic                ins_now;
  logic [AW-1:0]       dst;
  logic [CW-1:0]       room;
  logic [CW-1:0]       kmin;
  logic                j_last;

  // Result hand-over
  logic                res_issue;

  assign in_kind = s_tuser[KIND_W-1:0];
  assign pos_x   = XW'(s_tdata[39:32]);
  assign cnt_x   = XW'(count);
  assign ins_bad = (pos_x == '0) || ((pos_x - XW'(1)) > cnt_x);
  assign rd_bad  = (pos_x == '0) || (pos_x > cnt_x);

  assign match_now = (rdata == target_r);
  assign ins_now   = (kind_r == KIND_MATCH_INS) && match_now && (mrem <= k);
  assign dst       = AW'(CW'(j) + s);
  assign room      = CAP_C - count;
  assign kmin      = (m < room) ? m : room;
  assign j_last    = (CW'(j) == (count - CW'(1)));

  assign res_issue = (state == S_DONE) && (!m_tvalid || m_tready);

  assign s_tready = (state == S_IDLE);

  // Store port control
  always_comb begin
    we    = 1'b0;
    waddr = dst;
    wdata = rdata;
    re    = (state == S_F_RD) || (state == S_B_RD) || (state == S_R_RD);
    raddr = (state == S_R_RD) ? at : j;
    case (state)
      S_B_WR: begin
        we    = 1'b1;
        wdata = ins_now ? value_r : rdata;
      end
      S_B_MV: begin
        we = 1'b1;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = at;
        wdata = value_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  oaie_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (res_issue) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind_r   <= in_kind;
            value_r  <= s_tdata[31:0];
            target_r <= s_tdata[71:40];
            at       <= AW'(pos_x - XW'(1));
            ins_cnt  <= '0;
            rword    <= '0;
            m        <= '0;
            case (in_kind)
              KIND_POS_INS: begin
                if (ins_bad) begin
                  st    <= ST_BADPOS;
                  state <= S_DONE;
                end else if (count >= CAP_C) begin
                  st    <= ST_FULL;
                  state <= S_DONE;
                end else if ((pos_x - XW'(1)) == cnt_x) begin
                  st    <= ST_OK;
                  state <= S_PUT;
                end else begin
                  st    <= ST_OK;
                  j     <= AW'(count - CW'(1));
                  s     <= CW'(1);
                  state <= S_B_RD;
                end
              end
              KIND_MATCH_INS: begin
                st    <= ST_OK;
                j     <= '0;
                state <= (count == '0) ? S_DONE : S_F_RD;
              end
              KIND_READ: begin
                if (rd_bad) begin
                  st    <= ST_BADPOS;
                  state <= S_DONE;
                end else begin
                  st    <= ST_OK;
                  state <= S_R_RD;
                end
              end
              default: begin
                st    <= ST_BADPOS;
                state <= S_DONE;
              end
            endcase
          end
        end
        // Counting pass over the held words
        S_F_RD: begin
          state <= S_F_CMP;
        end
        S_F_CMP: begin
          m <= m + CW'(match_now);
          if (j_last) begin
            state <= S_B_INIT;
          end else begin
            j     <= AW'(j + 1'b1);
            state <= S_F_RD;
          end
        end
        // Inserts limited by free room; any match left over means full
        S_B_INIT: begin
          k       <= kmin;
          s       <= kmin;
          mrem    <= m;
          ins_cnt <= kmin;
          count   <= count + kmin;
          st      <= (m > room) ? ST_FULL : ST_OK;
          j       <= AW'(count - CW'(1));
          state   <= (kmin == '0) ? S_DONE : S_B_RD;
        end
        // Shift pass from the top down, one move per word
        S_B_RD: begin
          state <= S_B_WR;
        end
        S_B_WR: begin
          if (kind_r == KIND_MATCH_INS) begin
            if (match_now) begin
              mrem <= mrem - CW'(1);
            end
            if (ins_now) begin
              s     <= s - CW'(1);
              state <= S_B_MV;
            end else if ((j == '0) || (s == '0)) begin
              state <= S_DONE;
            end else begin
              j     <= AW'(j - 1'b1);
              state <= S_B_RD;
            end
          end else if (j == at) begin
            state <= S_PUT;
          end else begin
            j     <= AW'(j - 1'b1);
            state <= S_B_RD;
          end
        end
        S_B_MV: begin
          if ((j == '0) || (s == '0)) begin
            state <= S_DONE;
          end else begin
            j     <= AW'(j - 1'b1);
            state <= S_B_RD;
          end
        end
        S_PUT: begin
          count   <= count + CW'(1);
          ins_cnt <= CW'(1);
          state   <= S_DONE;
        end
        S_R_RD: begin
          state <= S_R_CAP;
        end
        S_R_CAP: begin
          rword <= rdata;
          state <= S_DONE;
        end
        // Hand the result to the output register once it is free
        S_DONE: begin
          if (res_issue) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (res_issue) begin
      m_tuser <= st;
      m_tdata <= {2'b00, OUT_CNT_W'(ins_cnt), OUT_CNT_W'(count), rword};
    end
  end

`ifndef SYNTH
  // Count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("word count above capacity");

  // An accepted request keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while busy");

  // A rejected position never reports an insert
  a_badpos_no_insert: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_BADPOS)) |-> (m_tdata[45:39] == '0))
    else $error("insert reported with invalid position");

  // A freshly issued result leaves the sequencer idle
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (!m_tvalid || m_tready)) |=> (m_tvalid && (state == S_IDLE)))
    else $error("result not issued from done state");
`endif

endmodule
